// ----- rtl/ppv_pkg.sv -----
// Package for the perspective projection and viewport block.
// Holds register indexes, shared widths and saturation helpers; no dependencies.
`timescale 1ns / 1ps
package ppv_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_F      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ASPECT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_Q      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZNEAR  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HEIGHT = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_EPS    = 3'd6;

  typedef struct packed {
    logic [30:0]        f;
    logic [30:0]        aspect;
    logic signed [31:0] q;
    logic signed [31:0] znear;
    logic [12:0]        width;
    logic [12:0]        height;
    logic [15:0]        eps;
  } cfg_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [65:0] v);
    if (v > 66'sd32767) return 16'sh7fff;
    else if (v < -66'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction
endpackage

// ----- rtl/perspective_project_viewport.sv -----
// Perspective projection and viewport transform, top level.
// Stages A to C, the dividers, stages D and E, then an output register; one item per cycle unless stalled.
// The long part is the bit-per-stage divider; a stall freezes the whole pipeline.
// Synchronous active-high reset clears valid bits and loads register defaults.
// Uses ppv_pkg and ppv_div.
`timescale 1ns / 1ps
module perspective_project_viewport #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // eye_x[31:0], eye_y[63:32], eye_z[95:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // pixel_x[15:0], pixel_y[31:16], depth[63:32]
  output logic        m_axis_tuser,  // w_near_zero
  input  logic        cfg_we,
  input  logic [ppv_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import ppv_pkg::*;
  localparam logic signed [65:0] ONE = 66'sd1 <<< FRAC_BITS;

  cfg_t cfg;
  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.f <= 31'd65536; cfg.aspect <= 31'd65536; cfg.q <= 32'sd65536;
      cfg.znear <= 32'sd6554; cfg.width <= 13'd80; cfg.height <= 13'd24;
      cfg.eps <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_F:      cfg.f      <= cfg_data[30:0];
        REG_ASPECT: cfg.aspect <= cfg_data[30:0];
        REG_Q:      cfg.q      <= cfg_data;
        REG_ZNEAR:  cfg.znear  <= cfg_data;
        REG_WIDTH:  cfg.width  <= cfg_data[12:0];
        REG_HEIGHT: cfg.height <= cfg_data[12:0];
        REG_EPS:    cfg.eps    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Truncating rescale of an exact product
  function automatic logic signed [65:0] rs(input logic signed [65:0] p);
    logic signed [65:0] a;
    a = (p < 0) ? -p : p;
    a = a >>> FRAC_BITS;
    return (p < 0) ? -a : a;
  endfunction

  logic en;
  logic out_full;
  assign en = !out_full || m_axis_tready;
  assign s_axis_tready = en;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  // Stage A: register input, form aspect*f and q*znear
  logic a_v; logic signed [31:0] a_x, a_y, a_z, a_af;
  logic signed [65:0] a_qzn;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0; else if (en) a_v <= acc;
    if (en) begin
      a_x <= s_axis_tdata[31:0]; a_y <= s_axis_tdata[63:32]; a_z <= s_axis_tdata[95:64];
      a_af  <= sat32(rs($signed({35'd0, cfg.aspect}) * $signed({35'd0, cfg.f})));
      a_qzn <= rs(66'(cfg.q) * 66'(cfg.znear));
    end
  end

  // Stage B: clip products, q*z and the near-zero flag
  logic b_v, b_nz; logic signed [31:0] b_cx, b_cy, b_z;
  logic signed [65:0] b_qz, b_qzn;
  logic [31:0] abs_z;
  assign abs_z = a_z[31] ? 32'(-a_z) : 32'(a_z);
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0; else if (en) b_v <= a_v;
    if (en) begin
      b_cx <= sat32(rs(66'(a_x) * 66'(a_af)));
      b_cy <= sat32(rs(66'(a_y) * $signed({35'd0, cfg.f})));
      b_qz <= rs(66'(cfg.q) * 66'(a_z));
      b_qzn <= a_qzn;
      b_z  <= a_z;
      b_nz <= ({a_z[31] & (a_z == 32'sh80000000), abs_z} <= {17'd0, cfg.eps});
    end
  end

  // Stage C: depth difference
  logic c_v, c_nz; logic signed [31:0] c_cx, c_cy, c_cz, c_z;
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0; else if (en) c_v <= b_v;
    if (en) begin
      c_cx <= b_cx; c_cy <= b_cy; c_z <= b_z; c_nz <= b_nz;
      c_cz <= sat32(b_qz - b_qzn);
    end
  end

  // Dividers; near-zero items carry clip values in the tag and bypass
  localparam int unsigned TW = 1 + 32;
  logic dx_v, dy_v, dz_v;
  logic signed [31:0] qx, qy, qz;
  logic [TW-1:0] tx, ty, tz;
  logic signed [31:0] safe_w;
  assign safe_w = c_nz ? 32'sd1 : c_z;
  ppv_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(TW)) u_div_x (
    .clk, .rst, .en, .in_valid(c_v), .c(c_cx), .w(safe_w), .in_tag({c_nz, c_cx}),
    .out_valid(dx_v), .q(qx), .out_tag(tx));
  ppv_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(TW)) u_div_y (
    .clk, .rst, .en, .in_valid(c_v), .c(c_cy), .w(safe_w), .in_tag({c_nz, c_cy}),
    .out_valid(dy_v), .q(qy), .out_tag(ty));
  ppv_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(TW)) u_div_z (
    .clk, .rst, .en, .in_valid(c_v), .c(c_cz), .w(safe_w), .in_tag({c_nz, c_cz}),
    .out_valid(dz_v), .q(qz), .out_tag(tz));

  // Stage D: select and add one
  logic d_v, d_nz; logic signed [31:0] d_sx, d_sy, d_sz;
  logic signed [31:0] nx, ny, nz;
  assign nx = tx[32] ? tx[31:0] : qx;
  assign ny = ty[32] ? ty[31:0] : qy;
  assign nz = tz[32] ? tz[31:0] : qz;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0; else if (en) d_v <= dx_v;
    if (en) begin
      d_nz <= tx[32];
      d_sx <= sat32(66'(nx) + ONE);
      d_sy <= sat32(66'(ny) + ONE);
      d_sz <= sat32(66'(nz) + ONE);
    end
  end

  // Stage E: scale by viewport size and halve the depth
  logic e_v, e_nz; logic signed [65:0] e_px, e_py; logic signed [31:0] e_dep;
  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0; else if (en) e_v <= d_v;
    if (en) begin
      e_nz <= d_nz;
      e_px <= 66'(d_sx) * $signed({53'd0, cfg.width});
      e_py <= 66'(d_sy) * $signed({53'd0, cfg.height});
      e_dep <= (d_sz < 0) ? -((-d_sz) >>> 1) : (d_sz >>> 1);
    end
  end

  function automatic logic signed [65:0] half_rs(input logic signed [65:0] p);
    logic signed [65:0] a;
    a = (p < 0) ? -p : p;
    a = a >>> (FRAC_BITS + 1);
    return (p < 0) ? -a : a;
  endfunction

  // Output register
  logic [63:0] o_data; logic o_user;
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0; else if (en) out_full <= e_v;
    if (en) begin
      o_data <= {e_dep, sat16(half_rs(e_py)), sat16(half_rs(e_px))};
      o_user <= e_nz;
    end
  end
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = o_data;
  assign m_axis_tuser  = o_user;

  a_valid_align: assert property (@(posedge clk) disable iff (rst)
    (dx_v == dy_v) && (dy_v == dz_v)) else $error("divider lanes out of step");
  a_tag_align: assert property (@(posedge clk) disable iff (rst)
    dx_v |-> (tx[32] == ty[32]) && (ty[32] == tz[32])) else $error("flag mismatch");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
endmodule

// ----- rtl/ppv_div.sv -----
// Pipelined signed divider: quotient = trunc((c << FRAC_BITS) / w).
// One quotient bit per stage, one item per cycle while en is high; uses ppv_pkg.
`timescale 1ns / 1ps
module ppv_div #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TAG_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [31:0]      c,
  input  logic signed [31:0]      w,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_valid,
  output logic signed [31:0]      q,
  output logic [TAG_W-1:0]        out_tag
);
  import ppv_pkg::*;
  localparam int unsigned NW = 32 + FRAC_BITS;   // dividend magnitude width
  localparam int unsigned DW = 32;               // divisor magnitude width

  logic          v   [NW+1];
  logic [NW-1:0] quo [NW+1];
  logic [DW:0]   rem [NW+1];
  logic [DW-1:0] dv  [NW+1];
  logic          neg [NW+1];
  logic [TAG_W-1:0] tg [NW+1];

  logic [NW-1:0] mag_c;
  logic [DW-1:0] mag_w;
  always_comb begin
    mag_c = {(c < 0 ? 32'(-c) : 32'(c)), {FRAC_BITS{1'b0}}};
    mag_w = (w < 0) ? 32'(-w) : 32'(w);
  end

  // Stage 0 registers the operands
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      quo[0] <= mag_c;
      rem[0] <= '0;
      dv[0]  <= mag_w;
      neg[0] <= c[31] ^ w[31];
      tg[0]  <= in_tag;
    end
  end

  // One restoring step per stage
  for (genvar s = 0; s < NW; s++) begin : g_step
    logic [DW+1:0] trial;
    logic [DW:0]   shifted;
    assign shifted = {rem[s][DW-1:0], quo[s][NW-1]};
    assign trial   = {1'b0, shifted} - {2'b00, dv[s]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
      if (en) begin
        if (!trial[DW+1]) begin
          rem[s+1] <= trial[DW:0];
          quo[s+1] <= {quo[s][NW-2:0], 1'b1};
        end else begin
          rem[s+1] <= shifted;
          quo[s+1] <= {quo[s][NW-2:0], 1'b0};
        end
        dv[s+1]  <= dv[s];
        neg[s+1] <= neg[s];
        tg[s+1]  <= tg[s];
      end
    end
  end

  logic signed [65:0] sq;
  always_comb begin
    sq = neg[NW] ? -$signed({{(66-NW){1'b0}}, quo[NW]})
                 :  $signed({{(66-NW){1'b0}}, quo[NW]});
  end
  assign out_valid = v[NW];
  assign q         = sat32(sq);
  assign out_tag   = tg[NW];
endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the perspective projection and viewport block.
// Predicts each vertex in fixed point and checks results in order; uses ppv_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  import ppv_pkg::*;

  localparam int FB = 16;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [31:0] depth;
    logic               nz_flag;
  } vtx_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // eye_x[31:0], eye_y[63:32], eye_z[95:64]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // pixel_x[15:0], pixel_y[31:16], depth[63:32]
  logic        m_axis_tuser;        // w_near_zero
  logic        cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  perspective_project_viewport #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the register file
  cfg_t shadow_cfg;
  vtx_res_t pending_px[$];
  int  n_err = 0, n_sent = 0, n_got = 0, n_near = 0;
  int  send_idle_pct = 9, recv_idle_pct = 72;
  bit  hold_recv = 1'b0;
  int  quiet_cycles = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Product rescaled, truncating toward zero (no 64-bit overflow for 32x32)
  function automatic longint fmul(longint a, longint b);
    return (a * b) / (64'sd1 << FB);
  endfunction

  function automatic longint to_px(longint n, longint size);
    longint s;
    s = clamp32(n + (64'sd1 << FB));
    return clamp16((s * size) / (64'sd1 << (FB + 1)));
  endfunction

  // Project one vertex with the current shadow registers
  function automatic vtx_res_t project_vertex(logic [95:0] v);
    longint x, y, z, af, cx, cy, cz, aw, nx, ny, nzv;
    bit near;
    vtx_res_t r;
    x = longint'($signed(v[31:0]));
    y = longint'($signed(v[63:32]));
    z = longint'($signed(v[95:64]));
    af = clamp32(fmul(longint'(shadow_cfg.aspect), longint'(shadow_cfg.f)));
    cx = clamp32(fmul(x, af));
    cy = clamp32(fmul(y, longint'(shadow_cfg.f)));
    cz = clamp32(fmul(longint'(shadow_cfg.q), z)
                 - fmul(longint'(shadow_cfg.q), longint'(shadow_cfg.znear)));
    aw = z < 0 ? -z : z;
    near = aw <= longint'(shadow_cfg.eps);
    if (near) begin
      nx = cx; ny = cy; nzv = cz;
    end else begin
      nx = clamp32((cx * (64'sd1 << FB)) / z);
      ny = clamp32((cy * (64'sd1 << FB)) / z);
      nzv = clamp32((cz * (64'sd1 << FB)) / z);
    end
    r.px = 16'(to_px(nx, longint'(shadow_cfg.width)));
    r.py = 16'(to_px(ny, longint'(shadow_cfg.height)));
    r.depth = 32'(clamp32(clamp32(nzv + (64'sd1 << FB)) / 2));
    r.nz_flag = near;
    return r;
  endfunction

  // Send one vertex; prediction is taken at acceptance
  task automatic send_vertex(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ez, ey, ex};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_px.push_back(project_vertex({ez, ey, ex}));
    n_sent++;
  endtask

  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // Write one register while idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_F:      shadow_cfg.f = val[30:0];
      REG_ASPECT: shadow_cfg.aspect = val[30:0];
      REG_Q:      shadow_cfg.q = val;
      REG_ZNEAR:  shadow_cfg.znear = val;
      REG_WIDTH:  shadow_cfg.width = val[12:0];
      REG_HEIGHT: shadow_cfg.height = val[12:0];
      REG_EPS:    shadow_cfg.eps = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000);
      2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [31:0] rand_depth();
    case ($urandom_range(7))
      0: return $urandom();
      1: return 32'($signed($urandom_range(300)) - 150);
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  // Receiver ready, with long hold-off on request
  always @(posedge clk) begin
    if (rst || hold_recv) m_axis_tready <= 1'b0;
    else m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    vtx_res_t exp_r, got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.px = m_axis_tdata[15:0];
      got.py = m_axis_tdata[31:16];
      got.depth = m_axis_tdata[63:32];
      got.nz_flag = m_axis_tuser;
      n_got++;
      if (pending_px.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR unexpected result %h", got);
      end else begin
        exp_r = pending_px.pop_front();
        if (exp_r.nz_flag) n_near++;
        if (got !== exp_r) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR px %0d/%0d py %0d/%0d depth %0d/%0d flag %0b/%0b (exp/got)",
                     exp_r.px, got.px, exp_r.py, got.py, exp_r.depth, got.depth,
                     exp_r.nz_flag, got.nz_flag);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // w exactly zero, at and just past epsilon on both sides
    send_vertex(32'h0000_8000, 32'hffff_8000, 32'h0);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'd66);
    send_vertex(32'h0001_0000, 32'h0001_0000, -32'sd66);
    send_vertex(32'h0001_0000, 32'h0001_0000, 32'd67);
    send_vertex(32'h0001_0000, 32'h0001_0000, -32'sd67);
    send_vertex(32'hffff_ffff, 32'h0, 32'h1);
    send_vertex(32'h0, 32'hffff_ffff, 32'hffff_ffff);
    drain_block();
  endtask

  task automatic test_extreme_regs();
    write_reg(REG_F, 32'hffff_ffff);
    write_reg(REG_ASPECT, 32'h7fff_ffff);
    write_reg(REG_Q, 32'h8000_0000);
    write_reg(REG_ZNEAR, 32'h7fff_ffff);
    write_reg(REG_WIDTH, 32'd4096);
    write_reg(REG_HEIGHT, 32'h1fff);
    write_reg(REG_EPS, 32'd0);
    write_reg(REG_UNMAPPED, 32'h1234_5678); // unmapped index, ignored
    send_vertex(32'h0001_0000, 32'hffff_0000, 32'h0);
    send_vertex(32'h0000_0100, 32'h0000_0100, 32'h0000_0001);
    send_vertex(32'h0, 32'h0, 32'hffff_ffff);
    drain_block();
    write_reg(REG_F, 32'd0);
    write_reg(REG_ASPECT, 32'd0);
    write_reg(REG_Q, 32'h7fff_ffff);
    write_reg(REG_ZNEAR, 32'h8000_0000);
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'd1);
    write_reg(REG_EPS, 32'hffff);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_ffff);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_vertex(32'h1234_5678, 32'h8765_4321, 32'hffff_0001);
    drain_block();
  endtask

  task automatic test_random(int n);
    repeat (n) send_vertex(rand_coord(), rand_coord(), rand_depth());
  endtask

  task automatic randomise_regs();
    write_reg(REG_F, $urandom_range(1 << 18));
    write_reg(REG_ASPECT, $urandom_range(1 << 18));
    write_reg(REG_Q, 32'($signed($urandom_range(1 << 19)) - (1 << 18)));
    write_reg(REG_ZNEAR, ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1 << 17));
    write_reg(REG_WIDTH, $urandom_range(4096, 1));
    write_reg(REG_HEIGHT, $urandom_range(4096, 1));
    write_reg(REG_EPS, $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(200));
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      test_random(120);
    join
    drain_block();
  endtask

  initial begin
    shadow_cfg = '{f: 31'd65536, aspect: 31'd65536, q: 32'sd65536, znear: 32'sd6554,
                   width: 13'd80, height: 13'd24, eps: 16'd66};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_extreme_regs();
    write_reg(REG_F, 32'd65536);
    write_reg(REG_ASPECT, 32'd49152);
    write_reg(REG_Q, 32'd70000);
    write_reg(REG_ZNEAR, 32'd6554);
    write_reg(REG_WIDTH, 32'd640);
    write_reg(REG_HEIGHT, 32'd480);
    write_reg(REG_EPS, 32'd66);
    test_random(385);
    drain_block();
    test_backpressure();
    // Swap idling: sender mostly idle, receiver eager
    send_idle_pct = 72; recv_idle_pct = 9;
    randomise_regs();
    test_random(385);
    drain_block();
    send_idle_pct = 0; recv_idle_pct = 0;
    randomise_regs();
    test_random(385);
    drain_block();
    $display("Covered %0d vertices (%0d near-zero w) over several register settings,",
             n_sent, n_near);
    $display("with random idling on both sides and a long output stall; %0d mismatches.",
             n_err);
    if (n_err == 0 && pending_px.size() == 0 && n_got == n_sent) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
